// ===== src/cst_pkg.sv =====
// Package: shared types and constants for the counting semaphore table.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_WAIT    = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_POST    = 3'd3,
    CMD_DESTROY = 3'd4,
    CMD_SNAP    = 3'd5,
    CMD_CLEANUP = 3'd6,
    CMD_BAD     = 3'd7
  } cmd_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BAD_HDL  = 4'd1;
  localparam logic [3:0] ST_BAD_ARGS = 4'd2;
  localparam logic [3:0] ST_NO_SLOT  = 4'd3;
  localparam logic [3:0] ST_KILLED   = 4'd4;
  localparam logic [3:0] ST_CLOSED   = 4'd5;
  localparam logic [3:0] ST_BLOCKED  = 4'd6;
  localparam logic [3:0] ST_AT_LIMIT = 4'd7;
  localparam logic [3:0] ST_NOT_OWN  = 4'd8;

  localparam int GEN_BITS = 23;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_step;
    logic scan_clear;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_scan;
    logic scan_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/cst_datapath.sv =====
// Datapath: slot table registers, command decode and result register.
`timescale 1ns / 1ps
`default_nettype none
module cst_datapath import cst_pkg::*; #(
  parameter int SLOT_COUNT       = 16,
  parameter int INDEX_FIELD_BITS = 8,
  parameter int GENERATION_LIMIT = 8388607
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctl_t        ctl,
  output sts_t             sts,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] handle,
  input  wire logic [31:0] initial_count,
  input  wire logic [31:0] count_limit,
  input  wire logic [15:0] requester_pid,
  input  wire logic        killed_flag,
  output logic [3:0]       status,
  output logic [30:0]      new_handle,
  output logic [15:0]      owner_id,
  output logic [30:0]      current_value,
  output logic [30:0]      permit_limit,
  output logic [15:0]      waiter_count,
  output logic [31:0]      wait_total,
  output logic [31:0]      post_total,
  output logic [31:0]      wake_total,
  output logic             wake_broadcast
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TW = INDEX_FIELD_BITS;

  logic              in_use  [SLOT_COUNT];
  logic              closing [SLOT_COUNT];
  logic [15:0]       owner   [SLOT_COUNT];
  logic [30:0]       permits [SLOT_COUNT];
  logic [30:0]       bound   [SLOT_COUNT];
  logic [15:0]       waiters [SLOT_COUNT];
  logic [GEN_BITS-1:0] gen   [SLOT_COUNT];
  logic [31:0]       wcnt    [SLOT_COUNT];
  logic [31:0]       pcnt    [SLOT_COUNT];
  logic [31:0]       kcnt    [SLOT_COUNT];

  // Latched request.
  cmd_t        cmd;
  logic [31:0] hdl;
  logic [31:0] init_q;
  logic [31:0] lim_q;
  logic [15:0] pid;
  logic        killed;
  logic [SW-1:0] scan;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd    <= cmd_t'(command);
      hdl    <= handle;
      init_q <= initial_count;
      lim_q  <= count_limit;
      pid    <= requester_pid;
      killed <= killed_flag;
    end
  end

  // Handle decode.
  logic [TW-1:0]  tag;
  logic [31:0]    hgen_w;
  logic           dec_ok;
  logic [SW-1:0]  s;
  logic [GEN_BITS-1:0] hgen;
  logic           hgen_fits;
  always_comb begin
    tag    = hdl[TW-1:0];
    hgen_w = hdl >> TW;
    hgen   = hgen_w[GEN_BITS-1:0];
    hgen_fits = ((hgen_w >> GEN_BITS) == 32'd0);
    dec_ok = (hdl != 32'd0) && !hdl[31] && (tag != '0)
             && ({{(32-TW){1'b0}}, tag} <= 32'(SLOT_COUNT)) && (hgen_w != 32'd0);
    s = SW'({{(32-TW){1'b0}}, tag} - 32'd1);
  end

  logic match;
  assign match = dec_ok && hgen_fits && in_use[s] && !closing[s] && (gen[s] == hgen);

  // Lowest free slot.
  logic          free_found;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  logic [GEN_BITS-1:0] gnext;
  logic [GEN_BITS:0]   ginc;
  always_comb begin
    ginc  = {1'b0, gen[free_idx]} + 1'b1;
    gnext = ginc[GEN_BITS-1:0];
    if (gnext == '0 || 32'(gnext) > 32'(GENERATION_LIMIT)) gnext = GEN_BITS'(1);
  end

  logic [63:0] hnew;
  assign hnew = ({41'd0, gnext} << TW) | 64'({{(32-TW){1'b0}}, TW'(free_idx) + TW'(1)});

  logic args_bad;
  assign args_bad = init_q[31] || lim_q[31] || (lim_q == 32'd0)
                    || ($signed(init_q) > $signed(lim_q));

  assign sts.is_scan   = (cmd == CMD_CLEANUP);
  assign sts.scan_last = (32'(scan) == 32'(SLOT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        in_use[i] <= 1'b0; closing[i] <= 1'b0; owner[i] <= '0;
        permits[i] <= '0; bound[i] <= '0; waiters[i] <= '0; gen[i] <= '0;
        wcnt[i] <= '0; pcnt[i] <= '0; kcnt[i] <= '0;
      end
    end else begin
      if (ctl.scan_clear) begin
        scan <= '0;
        status <= ST_OK; new_handle <= '0; owner_id <= '0; current_value <= '0;
        permit_limit <= '0; waiter_count <= '0; wait_total <= '0;
        post_total <= '0; wake_total <= '0; wake_broadcast <= 1'b0;
      end
      if (ctl.scan_step) begin
        scan <= scan + 1'b1;
        if (in_use[scan] && !closing[scan] && owner[scan] == pid) begin
          closing[scan] <= 1'b1;
          if (waiters[scan] != '0) begin
            kcnt[scan] <= kcnt[scan] + 1'b1;
            wake_broadcast <= 1'b1;
          end else begin
            in_use[scan] <= 1'b0; closing[scan] <= 1'b0; owner[scan] <= '0;
            permits[scan] <= '0; bound[scan] <= '0;
          end
        end
      end
      if (ctl.exec) begin
        status <= ST_OK; new_handle <= '0; owner_id <= '0; current_value <= '0;
        permit_limit <= '0; waiter_count <= '0; wait_total <= '0;
        post_total <= '0; wake_total <= '0; wake_broadcast <= 1'b0;
        unique case (cmd)
          CMD_CREATE: begin
            if (args_bad) status <= ST_BAD_ARGS;
            else if (!free_found) status <= ST_NO_SLOT;
            else begin
              gen[free_idx] <= gnext; in_use[free_idx] <= 1'b1;
              closing[free_idx] <= 1'b0; owner[free_idx] <= pid;
              permits[free_idx] <= init_q[30:0]; bound[free_idx] <= lim_q[30:0];
              waiters[free_idx] <= '0; wcnt[free_idx] <= '0;
              pcnt[free_idx] <= '0; kcnt[free_idx] <= '0;
              new_handle <= hnew[30:0];
            end
          end
          CMD_WAIT, CMD_RESUME: begin
            logic [15:0] w;
            logic        go;
            w  = waiters[s];
            go = 1'b1;
            if (!dec_ok) begin
              status <= ST_BAD_HDL; go = 1'b0;
            end else if (cmd == CMD_RESUME) begin
              if (w == '0) begin
                status <= ST_BAD_HDL; go = 1'b0;
              end else begin
                w = w - 1'b1;
                waiters[s] <= w;
                if (closing[s]) begin
                  status <= ST_CLOSED; go = 1'b0;
                  if (w == '0) begin
                    in_use[s] <= 1'b0; closing[s] <= 1'b0; owner[s] <= '0;
                    permits[s] <= '0; bound[s] <= '0;
                  end
                end
              end
            end
            if (go) begin
              if (!match) begin
                status <= ST_BAD_HDL;
                if (closing[s] && w == '0) begin
                  in_use[s] <= 1'b0; closing[s] <= 1'b0; owner[s] <= '0;
                  permits[s] <= '0; bound[s] <= '0;
                end
              end else if (killed) status <= ST_KILLED;
              else if (permits[s] != '0) begin
                permits[s] <= permits[s] - 1'b1;
                wcnt[s] <= wcnt[s] + 1'b1;
              end else begin
                status <= ST_BLOCKED;
                if (w != 16'hffff) waiters[s] <= w + 1'b1;
              end
            end
          end
          CMD_POST: begin
            if (!match) status <= ST_BAD_HDL;
            else if (permits[s] >= bound[s]) status <= ST_AT_LIMIT;
            else begin
              permits[s] <= permits[s] + 1'b1;
              pcnt[s] <= pcnt[s] + 1'b1;
              if (waiters[s] != '0) begin
                kcnt[s] <= kcnt[s] + 1'b1; wake_broadcast <= 1'b1;
              end
            end
          end
          CMD_DESTROY: begin
            if (!match) status <= ST_BAD_HDL;
            else if (owner[s] != pid) status <= ST_NOT_OWN;
            else begin
              closing[s] <= 1'b1;
              if (waiters[s] != '0) begin
                kcnt[s] <= kcnt[s] + 1'b1; wake_broadcast <= 1'b1;
              end else begin
                in_use[s] <= 1'b0; closing[s] <= 1'b0; owner[s] <= '0;
                permits[s] <= '0; bound[s] <= '0;
              end
            end
          end
          CMD_SNAP: begin
            if (!match) status <= ST_BAD_HDL;
            else begin
              owner_id <= owner[s]; current_value <= permits[s];
              permit_limit <= bound[s]; waiter_count <= waiters[s];
              wait_total <= wcnt[s]; post_total <= pcnt[s]; wake_total <= kcnt[s];
            end
          end
          CMD_CLEANUP: ;
          CMD_BAD: status <= ST_BAD_ARGS;
          default: status <= ST_BAD_ARGS;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cst_ctrl.sv =====
// Controller: sequences load, execute, owner scan and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module cst_ctrl import cst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ctl_t      ctl,
  input  wire sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_scan) begin
          ctl.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end else begin
          ctl.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/counting_semaphore_table.sv =====
// Top level: counting semaphore table with valid/ready request and result channels.
//
//  channel | direction | handshake               | word
//  in      | input     | in_valid / in_ready     | one command
//  out     | output    | out_valid / out_ready   | one result
//
// An ordinary command is executed in S_EXEC and offers its result in S_DONE; the next
// command is taken back in S_IDLE once the result has been accepted.
// Cleanup goes through S_EXEC, then walks the slot table in S_SCAN one slot a cycle.
// One command is held at a time; a stalled result holds the next command off.
// Reset clears the whole table at once.
`timescale 1ns / 1ps
`default_nettype none
module counting_semaphore_table import cst_pkg::*; #(
  parameter int SLOT_COUNT       = 16,
  parameter int INDEX_FIELD_BITS = 8,
  parameter int GENERATION_LIMIT = 8388607
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] handle,
  input  wire logic [31:0] initial_count,
  input  wire logic [31:0] count_limit,
  input  wire logic [15:0] requester_pid,
  input  wire logic        killed_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       status,
  output logic [30:0]      new_handle,
  output logic [15:0]      owner_id,
  output logic [30:0]      current_value,
  output logic [30:0]      permit_limit,
  output logic [15:0]      waiter_count,
  output logic [31:0]      wait_total,
  output logic [31:0]      post_total,
  output logic [31:0]      wake_total,
  output logic             wake_broadcast
);

  ctl_t ctl;
  sts_t sts;

  cst_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .ctl, .sts
  );

  cst_datapath #(
    .SLOT_COUNT(SLOT_COUNT),
    .INDEX_FIELD_BITS(INDEX_FIELD_BITS),
    .GENERATION_LIMIT(GENERATION_LIMIT)
  ) u_dp (
    .clk, .rst, .ctl, .sts, .command, .handle, .initial_count, .count_limit,
    .requester_pid, .killed_flag, .status, .new_handle, .owner_id,
    .current_value, .permit_limit, .waiter_count, .wait_total, .post_total,
    .wake_total, .wake_broadcast
  );

endmodule
`default_nettype wire

// ===== test/counting_semaphore_table_test.sv =====
// Self-checking testbench for the counting semaphore table: random and directed commands.
`timescale 1ns / 1ps
`default_nettype none
module counting_semaphore_table_test;
  import cst_pkg::*;

  localparam int SLOTS = 16;
  localparam int GEN_TOP = 8388607;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] hdl;
    logic [31:0] init;
    logic [31:0] lim;
    logic [15:0] pid;
    logic        killed;
  } request_t;

  typedef struct packed {
    logic [3:0]  st;
    logic [30:0] nh;
    logic [15:0] own;
    logic [30:0] cur;
    logic [30:0] bnd;
    logic [15:0] wtr;
    logic [31:0] wt;
    logic [31:0] pt;
    logic [31:0] kt;
    logic        wb;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] command = '0;
  logic [31:0] handle = '0;
  logic [31:0] initial_count = '0;
  logic [31:0] count_limit = '0;
  logic [15:0] requester_pid = '0;
  logic killed_flag = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] status;
  logic [30:0] new_handle;
  logic [15:0] owner_id;
  logic [30:0] current_value;
  logic [30:0] permit_limit;
  logic [15:0] waiter_count;
  logic [31:0] wait_total;
  logic [31:0] post_total;
  logic [31:0] wake_total;
  logic wake_broadcast;

  counting_semaphore_table dut (.*);

  always #5 clk = ~clk;

  // Mirror of the table.
  logic        m_use [SLOTS];
  logic        m_close [SLOTS];
  logic [15:0] m_own [SLOTS];
  logic [30:0] m_perm [SLOTS];
  logic [30:0] m_bound [SLOTS];
  logic [15:0] m_wait [SLOTS];
  logic [22:0] m_gen [SLOTS];
  logic [31:0] m_wt [SLOTS];
  logic [31:0] m_pt [SLOTS];
  logic [31:0] m_kt [SLOTS];

  request_t pending_words[$];
  reply_t   awaited_replies[$];
  logic [31:0] live_handles[$];
  int mismatches = 0;
  bit feeding_done = 0;

  function automatic bit split_handle(logic [31:0] h, output int s, output logic [22:0] g);
    logic [7:0] tag;
    s = 0;
    g = '0;
    if (h == 0 || h[31]) return 0;
    tag = h[7:0];
    if (tag == 0 || tag > SLOTS) return 0;
    if (h[30:8] == 0) return 0;
    g = h[30:8];
    s = tag - 1;
    return 1;
  endfunction

  function automatic bit slot_live(int s, logic [22:0] g);
    return m_use[s] && !m_close[s] && m_gen[s] == g;
  endfunction

  function automatic void retire_idle(int s);
    if (!m_close[s] || m_wait[s] != 0) return;
    m_use[s] = 0;
    m_close[s] = 0;
    m_own[s] = 0;
    m_perm[s] = 0;
    m_bound[s] = 0;
  endfunction

  function automatic logic close_one(int s);
    logic woke;
    woke = 0;
    m_close[s] = 1;
    if (m_wait[s] > 0) begin
      m_kt[s]++;
      woke = 1;
    end
    retire_idle(s);
    return woke;
  endfunction

  function automatic logic [3:0] take_permit(int s, logic [22:0] g, logic killed);
    if (!slot_live(s, g)) begin
      retire_idle(s);
      return ST_BAD_HDL;
    end
    if (killed) return ST_KILLED;
    if (m_perm[s] > 0) begin
      m_perm[s]--;
      m_wt[s]++;
      return ST_OK;
    end
    if (m_wait[s] != 16'hffff) m_wait[s]++;
    return ST_BLOCKED;
  endfunction

  function automatic reply_t run_command(request_t r);
    reply_t y;
    int s;
    logic [22:0] g;
    logic [22:0] ng;
    bit ok;
    y = '0;
    case (cmd_t'(r.cmd))
      CMD_CREATE: begin
        if ($signed(r.init) < 0 || $signed(r.lim) <= 0 || $signed(r.init) > $signed(r.lim)) begin
          y.st = ST_BAD_ARGS;
        end else begin
          y.st = ST_NO_SLOT;
          for (int i = 0; i < SLOTS; i++) begin
            if (!m_use[i]) begin
              ng = m_gen[i] + 1;
              if (ng == 0 || ng > GEN_TOP) ng = 1;
              m_gen[i] = ng;
              m_use[i] = 1;
              m_close[i] = 0;
              m_own[i] = r.pid;
              m_perm[i] = r.init[30:0];
              m_bound[i] = r.lim[30:0];
              m_wait[i] = 0;
              m_wt[i] = 0;
              m_pt[i] = 0;
              m_kt[i] = 0;
              y.st = ST_OK;
              y.nh = {ng, 8'(i + 1)};
              break;
            end
          end
        end
      end
      CMD_WAIT: begin
        if (!split_handle(r.hdl, s, g)) y.st = ST_BAD_HDL;
        else y.st = take_permit(s, g, r.killed);
      end
      CMD_RESUME: begin
        if (!split_handle(r.hdl, s, g) || m_wait[s] == 0) begin
          y.st = ST_BAD_HDL;
        end else begin
          m_wait[s]--;
          if (m_close[s]) begin
            retire_idle(s);
            y.st = ST_CLOSED;
          end else begin
            y.st = take_permit(s, g, r.killed);
          end
        end
      end
      CMD_POST: begin
        if (!split_handle(r.hdl, s, g) || !slot_live(s, g)) y.st = ST_BAD_HDL;
        else if (m_perm[s] >= m_bound[s]) y.st = ST_AT_LIMIT;
        else begin
          m_perm[s]++;
          m_pt[s]++;
          if (m_wait[s] > 0) begin
            m_kt[s]++;
            y.wb = 1;
          end
        end
      end
      CMD_DESTROY: begin
        if (!split_handle(r.hdl, s, g) || !slot_live(s, g)) y.st = ST_BAD_HDL;
        else if (m_own[s] != r.pid) y.st = ST_NOT_OWN;
        else y.wb = close_one(s);
      end
      CMD_SNAP: begin
        ok = split_handle(r.hdl, s, g);
        if (!ok || !slot_live(s, g)) y.st = ST_BAD_HDL;
        else begin
          y.own = m_own[s];
          y.cur = m_perm[s];
          y.bnd = m_bound[s];
          y.wtr = m_wait[s];
          y.wt = m_wt[s];
          y.pt = m_pt[s];
          y.kt = m_kt[s];
        end
      end
      CMD_CLEANUP: begin
        for (int i = 0; i < SLOTS; i++)
          if (m_use[i] && !m_close[i] && m_own[i] == r.pid) y.wb |= close_one(i);
      end
      default: y.st = ST_BAD_ARGS;
    endcase
    return y;
  endfunction

  function automatic request_t make_word(cmd_t c, logic [31:0] h, logic [31:0] ini,
                                         logic [31:0] lim, logic [15:0] pid, logic k);
    request_t r;
    r.cmd = c;
    r.hdl = h;
    r.init = ini;
    r.lim = lim;
    r.pid = pid;
    r.killed = k;
    return r;
  endfunction

  function automatic logic [31:0] pick_handle();
    int n;
    n = $urandom_range(0, 19);
    if (live_handles.size() == 0 || n == 0) return $urandom;
    if (n == 1) return {1'b0, 23'($urandom_range(1, 4)), 8'($urandom_range(0, 20))};
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  // Random command biased towards well-formed use of a few owners.
  function automatic request_t random_word();
    int n;
    logic [31:0] lim;
    logic [15:0] pid;
    n = $urandom_range(0, 99);
    pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
    lim = $urandom_range(1, 4);
    if (n < 14) begin
      if ($urandom_range(0, 9) == 0)
        return make_word(CMD_CREATE, $urandom, $urandom, $urandom, pid, 1'($urandom));
      return make_word(CMD_CREATE, $urandom, $urandom_range(0, lim), lim, pid, 1'($urandom));
    end
    if (n < 34) return make_word(CMD_WAIT, pick_handle(), $urandom, $urandom, pid,
                                 $urandom_range(0, 7) == 0);
    if (n < 50) return make_word(CMD_RESUME, pick_handle(), $urandom, $urandom, pid,
                                 $urandom_range(0, 7) == 0);
    if (n < 68) return make_word(CMD_POST, pick_handle(), $urandom, $urandom, pid,
                                 1'($urandom));
    if (n < 78) return make_word(CMD_DESTROY, pick_handle(), $urandom, $urandom, pid,
                                 1'($urandom));
    if (n < 94) return make_word(CMD_SNAP, pick_handle(), $urandom, $urandom, pid,
                                 1'($urandom));
    if (n < 98) return make_word(CMD_CLEANUP, $urandom, $urandom, $urandom, pid,
                                 1'($urandom));
    return make_word(CMD_BAD, $urandom, $urandom, $urandom, pid, 1'($urandom));
  endfunction

  task automatic queue_word(request_t r);
    pending_words.push_back(r);
  endtask

  initial begin
    request_t r;
    logic [31:0] big;
    for (int i = 0; i < SLOTS; i++) begin
      m_use[i] = 0; m_close[i] = 0; m_own[i] = 0; m_perm[i] = 0; m_bound[i] = 0;
      m_wait[i] = 0; m_gen[i] = 0; m_wt[i] = 0; m_pt[i] = 0; m_kt[i] = 0;
    end
    big = 32'h7fffffff;
    queue_word(make_word(CMD_CREATE, 0, 32'hffffffff, 5, 1, 0));
    queue_word(make_word(CMD_CREATE, 0, 0, 0, 1, 0));
    queue_word(make_word(CMD_CREATE, 0, 6, 5, 1, 0));
    queue_word(make_word(CMD_CREATE, 0, 32'h80000000, 32'h80000000, 1, 0));
    queue_word(make_word(CMD_CREATE, 32'hffffffff, big, big, 16'hffff, 1));
    queue_word(make_word(CMD_CREATE, 0, 0, 1, 2, 0));
    queue_word(make_word(CMD_WAIT, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_WAIT, 32'h102, 0, 0, 2, 1));
    queue_word(make_word(CMD_POST, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_POST, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_RESUME, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_RESUME, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_POST, 32'h101, 0, 0, 2, 0));
    queue_word(make_word(CMD_SNAP, 32'h101, 0, 0, 0, 0));
    queue_word(make_word(CMD_WAIT, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_DESTROY, 32'h102, 0, 0, 7, 0));
    queue_word(make_word(CMD_DESTROY, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_RESUME, 32'h102, 0, 0, 2, 0));
    queue_word(make_word(CMD_SNAP, 32'h80000101, 0, 0, 0, 0));
    queue_word(make_word(CMD_SNAP, 32'h011, 0, 0, 0, 0));
    queue_word(make_word(CMD_CLEANUP, 32'hffffffff, 0, 0, 16'hffff, 0));
    queue_word(make_word(CMD_BAD, 32'h101, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++) queue_word(make_word(CMD_CREATE, 0, 1, 2, 3, 0));
    queue_word(make_word(CMD_CLEANUP, 0, 0, 0, 3, 0));
    for (int i = 0; i < 1700; i++) begin
      if ((i % 400) == 399) queue_word(make_word(CMD_CLEANUP, 0, 0, 0, 16'($urandom_range(1, 3)), 0));
      else begin
        r = random_word();
        queue_word(r);
      end
    end
    feeding_done = 1;
  end

  int send_gap = 0;
  int recv_gap = 0;
  reply_t y;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        y = run_command({command, handle, initial_count, count_limit, requester_pid, killed_flag});
        awaited_replies.push_back(y);
        if (y.st == ST_OK && y.nh != 0) begin
          live_handles.push_back({1'b0, y.nh});
          if (live_handles.size() > 24) void'(live_handles.pop_front());
        end
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || pending_words.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          {command, handle, initial_count, count_limit, requester_pid, killed_flag}
            <= pending_words.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, new_handle, owner_id, current_value, permit_limit, waiter_count,
               wait_total, post_total, wake_total, wake_broadcast};
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (feeding_done && pending_words.size() == 0 && !in_valid && awaited_replies.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
